### rtl/mts_pkg.sv
// Shared types, constants and keyword tables for the markup token scanner.
package mts_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int LINE_BITS   = 32;
	localparam int KW_COUNT    = 9;
	localparam int KW_MAXLEN   = 13;
	localparam int KW_BITS     = 8 * KW_MAXLEN;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	typedef logic [QPTR_BITS-1:0] qptr_t;
	typedef logic [QPTR_BITS:0]   qcount_t;

	localparam qcount_t QUEUE_ACCEPT_MAX = qcount_t'(QUEUE_DEPTH - 2);

	typedef enum logic [2:0] {
		MODE_NORMAL   = 3'd0,
		MODE_SLASH    = 3'd1,
		MODE_LINECMT  = 3'd2,
		MODE_BLOCKCMT = 3'd3,
		MODE_GEN      = 3'd4,
		MODE_STRING   = 3'd5,
		MODE_IDENT    = 3'd6
	} scan_mode_t;

	typedef enum logic [4:0] {
		TK_EOF        = 5'd0,
		TK_LBRACE     = 5'd1,
		TK_RBRACE     = 5'd2,
		TK_SEMI       = 5'd3,
		TK_SLASH      = 5'd4,
		TK_GENCMT     = 5'd5,
		TK_STRING     = 5'd6,
		TK_IDENT      = 5'd7,
		TK_KW_FIRST   = 5'd8,
		TK_BADCHAR    = 5'd17,
		TK_UNTERM     = 5'd18
	} tok_kind_t;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;

	localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
		KW_BITS'("Template"), KW_BITS'("Custom"), KW_BITS'("Origin"),
		KW_BITS'("Import"), KW_BITS'("Namespace"), KW_BITS'("Configuration"),
		KW_BITS'("text"), KW_BITS'("style"), KW_BITS'("script")
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd8, 4'd6, 4'd6, 4'd6, 4'd9, 4'd13, 4'd4, 4'd5, 4'd6
	};

	typedef struct packed {
		tok_kind_t              kind;
		logic [OFFSET_BITS-1:0] start;
		logic [OFFSET_BITS-1:0] length;
		logic [LINE_BITS-1:0]   line;
		logic                   last;
	} token_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic [KW_COUNT-1:0] kw_match(input logic [3:0] idx,
			input logic [7:0] c);
		logic [KW_COUNT-1:0] m;
		int pos;
		m = '0;
		for (int k = 0; k < KW_COUNT; k++) begin
			pos = int'(KW_LEN[k]) - 1 - int'(idx);
			if (pos >= 0)
				m[k] = (KW_TEXT[k][8*pos +: 8] == c);
		end
		return m;
	endfunction

	function automatic tok_kind_t kw_kind(input logic [KW_COUNT-1:0] live,
			input logic [3:0] idx);
		tok_kind_t kind;
		kind = TK_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (live[k] && idx == KW_LEN[k])
				kind = tok_kind_t'(5'(int'(TK_KW_FIRST) + k));
		end
		return kind;
	endfunction

endpackage

### rtl/markup_token_scanner.sv
// Top level of the markup token scanner: input stage, decode core, result queue.
// Order: an accepted byte is held in the input stage and decoded from there; its tokens
// go into the result queue when it has room, the first then on the master side, a second one transfer later.
// Throughput: one byte per cycle while the four-entry result queue has two free slots;
// that space check means a run of two-token bytes, with m_tready held, paces at one token a cycle.
// Reset: arst_n clears the scanner state, input stage and queue at once.
module markup_token_scanner (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tuser,   // [0] end_marker
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // [4:0] token_kind, [36:5] lexeme_start,
	                                // [68:37] lexeme_length, [100:69] line_number
	output logic         m_tlast    // last_of_run
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              end_s1;
	logic              advance;
	logic [1:0]        tok_count;
	mts_pkg::token_t   tok0, tok1;
	mts_pkg::token_t   queue_q [mts_pkg::QUEUE_DEPTH];
	mts_pkg::qptr_t    wr_ptr_q, rd_ptr_q;
	mts_pkg::qcount_t  count_q;
	logic              pop;
	mts_pkg::token_t   head;

	assign advance  = valid_s1 && (count_q <= mts_pkg::QUEUE_ACCEPT_MAX);
	assign s_tready = !valid_s1 || advance;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tuser;
		end
	end

	mts_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.data_byte  (byte_s1),
		.end_marker (end_s1),
		.tok_count  (tok_count),
		.tok0       (tok0),
		.tok1       (tok1)
	);

	always_ff @(posedge clk) begin
		if (advance && tok_count != 2'd0)
			queue_q[wr_ptr_q] <= tok0;
		if (advance && tok_count == 2'd2)
			queue_q[wr_ptr_q + mts_pkg::qptr_t'(1)] <= tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (advance)
				wr_ptr_q <= wr_ptr_q + mts_pkg::qptr_t'(tok_count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + mts_pkg::qptr_t'(1);
			count_q <= count_q + (advance ? mts_pkg::qcount_t'(tok_count) : '0)
				- mts_pkg::qcount_t'(pop);
		end
	end

	assign head     = queue_q[rd_ptr_q];
	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {3'b000, head.line, head.length, head.start, 5'(head.kind)};
	assign m_tlast  = head.last;

endmodule

### rtl/mts_core.sv
// Scanner state and single-pass token decode for one source byte or end marker.
module mts_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          data_byte,
	input  logic                end_marker,
	output logic [1:0]          tok_count,
	output mts_pkg::token_t     tok0,
	output mts_pkg::token_t     tok1
);

	mts_pkg::scan_mode_t                   mode_q, mode_d;
	logic                                  star_q, star_d;
	logic [mts_pkg::OFFSET_BITS-1:0]       pos_q, pos_d;
	logic [mts_pkg::OFFSET_BITS-1:0]       begin_q, begin_d;
	logic [mts_pkg::LINE_BITS-1:0]         line_q, line_d;
	logic [mts_pkg::KW_COUNT-1:0]          live_q, live_d;
	logic [3:0]                            idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= mts_pkg::MODE_NORMAL;
			star_q  <= 1'b0;
			pos_q   <= '0;
			begin_q <= '0;
			line_q  <= mts_pkg::LINE_BITS'(1);
			live_q  <= '1;
			idx_q   <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			star_q  <= star_d;
			pos_q   <= pos_d;
			begin_q <= begin_d;
			line_q  <= line_d;
			live_q  <= live_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		logic [mts_pkg::OFFSET_BITS-1:0] next_pos;
		logic [mts_pkg::LINE_BITS-1:0]   line_inc;
		logic [3:0]                      idx_inc;
		logic                            do_norm;
		logic                            a_vld, b_vld;
		mts_pkg::token_t                 tok_a, tok_b;

		next_pos = (pos_q != '1) ? pos_q + 1'b1 : pos_q;
		line_inc = (line_q != '1) ? line_q + 1'b1 : line_q;
		idx_inc  = (idx_q != 4'hF) ? idx_q + 4'd1 : idx_q;

		mode_d  = mode_q;
		star_d  = star_q;
		pos_d   = pos_q;
		begin_d = begin_q;
		line_d  = line_q;
		live_d  = live_q;
		idx_d   = idx_q;
		do_norm = 1'b0;
		a_vld   = 1'b0;
		b_vld   = 1'b0;
		tok_a   = '{kind: mts_pkg::TK_EOF, start: begin_q, length: '0, line: line_q,
			last: 1'b0};
		tok_b   = '{kind: mts_pkg::TK_EOF, start: pos_q, length: mts_pkg::OFFSET_BITS'(1),
			line: line_q, last: 1'b0};

		if (end_marker) begin
			unique case (mode_q)
				mts_pkg::MODE_SLASH: begin
					a_vld = 1'b1;
					tok_a.kind = mts_pkg::TK_SLASH;
					tok_a.length = mts_pkg::OFFSET_BITS'(1);
				end
				mts_pkg::MODE_GEN: begin
					a_vld = 1'b1;
					tok_a.kind = mts_pkg::TK_GENCMT;
					tok_a.length = pos_q - begin_q;
				end
				mts_pkg::MODE_STRING: begin
					a_vld = 1'b1;
					tok_a.kind = mts_pkg::TK_UNTERM;
					tok_a.length = pos_q - begin_q;
				end
				mts_pkg::MODE_IDENT: begin
					a_vld = 1'b1;
					tok_a.kind = mts_pkg::kw_kind(live_q, idx_q);
					tok_a.length = pos_q - begin_q;
				end
				default: ;
			endcase
			b_vld = 1'b1;
			tok_b.kind = mts_pkg::TK_EOF;
			tok_b.length = '0;
			mode_d  = mts_pkg::MODE_NORMAL;
			star_d  = 1'b0;
			pos_d   = '0;
			begin_d = '0;
			line_d  = mts_pkg::LINE_BITS'(1);
			live_d  = '1;
			idx_d   = '0;
		end else begin
			pos_d = next_pos;
			unique case (mode_q)
				mts_pkg::MODE_SLASH: begin
					if (data_byte == mts_pkg::CH_SLASH) begin
						mode_d = mts_pkg::MODE_LINECMT;
					end else if (data_byte == mts_pkg::CH_STAR) begin
						mode_d = mts_pkg::MODE_BLOCKCMT;
						star_d = 1'b0;
					end else begin
						a_vld = 1'b1;
						tok_a.kind = mts_pkg::TK_SLASH;
						tok_a.length = mts_pkg::OFFSET_BITS'(1);
						do_norm = 1'b1;
					end
				end
				mts_pkg::MODE_LINECMT: begin
					do_norm = (data_byte == mts_pkg::CH_LF);
				end
				mts_pkg::MODE_BLOCKCMT: begin
					if (star_q && data_byte == mts_pkg::CH_SLASH) begin
						mode_d = mts_pkg::MODE_NORMAL;
						star_d = 1'b0;
					end else begin
						if (data_byte == mts_pkg::CH_LF)
							line_d = line_inc;
						star_d = (data_byte == mts_pkg::CH_STAR);
					end
				end
				mts_pkg::MODE_GEN: begin
					if (data_byte == mts_pkg::CH_LF) begin
						a_vld = 1'b1;
						tok_a.kind = mts_pkg::TK_GENCMT;
						tok_a.length = pos_q - begin_q;
						do_norm = 1'b1;
					end
				end
				mts_pkg::MODE_STRING: begin
					if (data_byte == mts_pkg::CH_QUOTE) begin
						a_vld = 1'b1;
						tok_a.kind = mts_pkg::TK_STRING;
						tok_a.length = next_pos - begin_q;
						mode_d = mts_pkg::MODE_NORMAL;
					end else if (data_byte == mts_pkg::CH_LF) begin
						line_d = line_inc;
					end
				end
				mts_pkg::MODE_IDENT: begin
					if (mts_pkg::is_alnum(data_byte)) begin
						live_d = live_q & mts_pkg::kw_match(idx_q, data_byte);
						idx_d  = idx_inc;
					end else begin
						a_vld = 1'b1;
						tok_a.kind = mts_pkg::kw_kind(live_q, idx_q);
						tok_a.length = pos_q - begin_q;
						do_norm = 1'b1;
					end
				end
				default: do_norm = 1'b1;
			endcase

			if (do_norm) begin
				mode_d = mts_pkg::MODE_NORMAL;
				case (data_byte) inside
					mts_pkg::CH_LBRACE: begin
						b_vld = 1'b1;
						tok_b.kind = mts_pkg::TK_LBRACE;
					end
					mts_pkg::CH_RBRACE: begin
						b_vld = 1'b1;
						tok_b.kind = mts_pkg::TK_RBRACE;
					end
					mts_pkg::CH_SEMI: begin
						b_vld = 1'b1;
						tok_b.kind = mts_pkg::TK_SEMI;
					end
					mts_pkg::CH_SLASH: begin
						mode_d = mts_pkg::MODE_SLASH;
						begin_d = pos_q;
					end
					mts_pkg::CH_HASH: begin
						mode_d = mts_pkg::MODE_GEN;
						begin_d = pos_q;
					end
					mts_pkg::CH_QUOTE: begin
						mode_d = mts_pkg::MODE_STRING;
						begin_d = pos_q;
					end
					mts_pkg::CH_SPACE, mts_pkg::CH_CR, mts_pkg::CH_TAB: ;
					mts_pkg::CH_LF: line_d = line_inc;
					default: begin
						if (mts_pkg::is_alpha(data_byte)) begin
							mode_d = mts_pkg::MODE_IDENT;
							begin_d = pos_q;
							live_d = mts_pkg::kw_match(4'd0, data_byte);
							idx_d = 4'd1;
						end else begin
							b_vld = 1'b1;
							tok_b.kind = mts_pkg::TK_BADCHAR;
						end
					end
				endcase
			end
		end

		tok_b.last = b_vld;
		tok_a.last = !b_vld;
		tok_count = 2'(a_vld) + 2'(b_vld);
		tok0 = a_vld ? tok_a : tok_b;
		tok1 = tok_b;
	end

endmodule
